// ===== hw/rtl/tpmq_pkg.sv =====
// Shared types and constants for the trip/parking motion qualifier.
// Holds the configuration register indexes and the structs passed between modules.
// No dependencies.
package tpmq_pkg;

    localparam int unsigned CfgAddrW = 2;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned TimeW    = 32;
    localparam int unsigned OdoW     = 32;

    localparam logic [CfgAddrW-1:0] CFG_IGN_STOP_EN          = 2'd0;
    localparam logic [CfgAddrW-1:0] CFG_MIN_TRIP_DURATION    = 2'd1;
    localparam logic [CfgAddrW-1:0] CFG_MIN_TRIP_DISTANCE    = 2'd2;
    localparam logic [CfgAddrW-1:0] CFG_MIN_PARKING_DURATION = 2'd3;

    localparam logic [TimeW-1:0] RST_MIN_TRIP_DURATION    = 32'd300;
    localparam logic [OdoW-1:0]  RST_MIN_TRIP_DISTANCE    = 32'd500;
    localparam logic [TimeW-1:0] RST_MIN_PARKING_DURATION = 32'd300;

    typedef struct packed {
        logic             ign_stop_en;
        logic [TimeW-1:0] min_trip_duration;
        logic [OdoW-1:0]  min_trip_distance;
        logic [TimeW-1:0] min_parking_duration;
    } t_cfg;

    typedef struct packed {
        logic             moving_now;
        logic [TimeW-1:0] fix_seconds;
        logic [OdoW-1:0]  odometer_meters;
        logic             ignition_present;
        logic             ignition_on;
    } t_report;

    typedef struct packed {
        logic event_raised;
        logic event_moving;
        logic motion_now;
    } t_result;

endpackage

// ===== hw/rtl/tpmq_cfg_regs.sv =====
// Configuration register bank of the motion qualifier.
// Depends on tpmq_pkg for register indexes, reset values and the t_cfg struct.
module tpmq_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpmq_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  logic [tpmq_pkg::CfgDataW-1:0]  i_cfg_data,
    output tpmq_pkg::t_cfg                 o_cfg
);
    import tpmq_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ign_stop_en          <= 1'b0;
            r_cfg.min_trip_duration    <= RST_MIN_TRIP_DURATION;
            r_cfg.min_trip_distance    <= RST_MIN_TRIP_DISTANCE;
            r_cfg.min_parking_duration <= RST_MIN_PARKING_DURATION;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IGN_STOP_EN: begin
                    r_cfg.ign_stop_en <= i_cfg_data[0];
                end
                CFG_MIN_TRIP_DURATION: begin
                    r_cfg.min_trip_duration <= i_cfg_data[TimeW-1:0];
                end
                CFG_MIN_TRIP_DISTANCE: begin
                    r_cfg.min_trip_distance <= i_cfg_data[OdoW-1:0];
                end
                CFG_MIN_PARKING_DURATION: begin
                    r_cfg.min_parking_duration <= i_cfg_data[TimeW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/tpmq_qualifier.sv =====
// Motion state, confirmed streak and pending mark, with the per-report decision logic.
// Depends on tpmq_pkg for the t_cfg, t_report and t_result structs.
module tpmq_qualifier (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  tpmq_pkg::t_report i_report,
    input  tpmq_pkg::t_cfg    i_cfg,
    output tpmq_pkg::t_result o_result
);
    import tpmq_pkg::*;

    logic             r_motion_flag;
    logic             r_confirmed_streak;
    logic             r_mark_armed;
    logic [TimeW-1:0] r_mark_seconds;
    logic [OdoW-1:0]  r_mark_meters;

    logic             n_motion_flag;
    logic             n_confirmed_streak;
    logic             n_mark_armed;
    logic [TimeW-1:0] n_mark_seconds;
    logic [OdoW-1:0]  n_mark_meters;

    logic [TimeW:0]   w_dt;
    logic [OdoW:0]    w_dd;
    logic             w_trip_time_ok;
    logic             w_trip_dist_ok;
    logic             w_park_time_ok;
    logic             w_ign_off;
    logic             w_fire;
    t_result          w_result;

    // The extra top bit of each difference is the borrow: a report that goes
    // backwards in time or distance never qualifies.
    assign w_dt = {1'b0, i_report.fix_seconds} - {1'b0, r_mark_seconds};
    assign w_dd = {1'b0, i_report.odometer_meters} - {1'b0, r_mark_meters};

    assign w_trip_time_ok = !w_dt[TimeW] && (w_dt[TimeW-1:0] >= i_cfg.min_trip_duration);
    assign w_trip_dist_ok = !w_dd[OdoW] && (w_dd[OdoW-1:0] >= i_cfg.min_trip_distance);
    assign w_park_time_ok = !w_dt[TimeW] && (w_dt[TimeW-1:0] >= i_cfg.min_parking_duration);
    assign w_ign_off      = i_cfg.ign_stop_en && i_report.ignition_present
                            && !i_report.ignition_on;

    assign w_fire = i_report.moving_now ? (w_trip_time_ok || w_trip_dist_ok)
                                        : (w_park_time_ok || w_ign_off);

    always_comb begin
        n_motion_flag      = r_motion_flag;
        n_confirmed_streak = r_confirmed_streak;
        n_mark_armed       = r_mark_armed;
        n_mark_seconds     = r_mark_seconds;
        n_mark_meters      = r_mark_meters;
        w_result           = '0;
        if (i_report.moving_now == r_motion_flag) begin
            if (r_mark_armed && w_fire) begin
                w_result.event_raised = 1'b1;
                w_result.event_moving = i_report.moving_now;
                n_confirmed_streak    = i_report.moving_now;
                n_mark_armed          = 1'b0;
                n_mark_seconds        = '0;
                n_mark_meters         = '0;
            end
        end else begin
            n_motion_flag = i_report.moving_now;
            if (r_confirmed_streak == i_report.moving_now) begin
                // Back to the confirmed state: drop the mark, the stale time is never read.
                n_mark_armed  = 1'b0;
                n_mark_meters = '0;
            end else begin
                n_mark_armed   = 1'b1;
                n_mark_seconds = i_report.fix_seconds;
                n_mark_meters  = i_report.odometer_meters;
            end
        end
        w_result.motion_now = n_motion_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_flag      <= 1'b0;
            r_confirmed_streak <= 1'b0;
            r_mark_armed       <= 1'b0;
            r_mark_seconds     <= '0;
            r_mark_meters      <= '0;
        end else if (i_step) begin
            r_motion_flag      <= n_motion_flag;
            r_confirmed_streak <= n_confirmed_streak;
            r_mark_armed       <= n_mark_armed;
            r_mark_seconds     <= n_mark_seconds;
            r_mark_meters      <= n_mark_meters;
        end
    end

    assign o_result = w_result;

    a_armed_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mark_armed |-> (r_motion_flag != r_confirmed_streak))
        else $error("pending mark held while state matches confirmed streak");

    a_idle_meters_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_mark_armed |-> (r_mark_meters == '0))
        else $error("mark distance left over without a pending mark");

    a_event_clears_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_result.event_raised) |=> (!r_mark_armed && r_mark_seconds == '0))
        else $error("mark not cleared after an event");

    a_event_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_result.event_raised |-> (w_result.event_moving == w_result.motion_now))
        else $error("event kind disagrees with motion state");

endmodule

// ===== hw/rtl/trip_parking_motion_qualifier_core.sv =====
// Top level of the trip/parking motion qualifier: input register, output register
// and handshake control. Depends on tpmq_pkg, tpmq_cfg_regs and tpmq_qualifier.
//
// A report is held in the input register, then its result in the output register.
// Throughput: one report per cycle; while a result waits in the output register under
// stall, the input register takes one more report and then stalls the input.
// Reset: synchronous, active low; clears the motion state, the pending mark and
// loads the register defaults (ignition stop disabled, 300 s, 500 m, 300 s).
module trip_parking_motion_qualifier_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tpmq_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  logic [tpmq_pkg::CfgDataW-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_moving_now,
    input  logic [tpmq_pkg::TimeW-1:0]     i_fix_seconds,
    input  logic [tpmq_pkg::OdoW-1:0]      i_odometer_meters,
    input  logic                           i_ignition_present,
    input  logic                           i_ignition_on,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_event_raised,
    output logic                           o_event_moving,
    output logic                           o_motion_now
);
    import tpmq_pkg::*;

    t_cfg    w_cfg;
    t_report r_in;
    logic    r_in_valid;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_advance;

    tpmq_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tpmq_qualifier u_qual (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_report (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // A report moves into the qualifier when the output register is free or drains.
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in.moving_now       <= i_moving_now;
            r_in.fix_seconds      <= i_fix_seconds;
            r_in.odometer_meters  <= i_odometer_meters;
            r_in.ignition_present <= i_ignition_present;
            r_in.ignition_on      <= i_ignition_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_event_raised = r_out.event_raised;
    assign o_event_moving = r_out.event_moving;
    assign o_motion_now   = r_out.motion_now;

endmodule
